FILE: rtl/lsh_pkg.sv
// Shared constants, command type and helpers for the Laplacian sharpening block.
package lsh_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W  = 8;
   localparam int SIZE_W = 11;
   localparam int GAIN_W = 9;
   localparam int CSR_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;

   // register indexes on the csr port
   localparam logic [1:0] CSR_FILTER_KIND  = 2'd0;
   localparam logic [1:0] CSR_GAIN         = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd3;

   localparam logic KIND_FIVE_POINT = 1'b0;

   localparam logic [SIZE_W-1:0] CENTRE_FIVE  = 11'd400;
   localparam logic [SIZE_W-1:0] CENTRE_NINE  = 11'd800;
   localparam logic [6:0]        NBR_SCALE    = 7'd100;
   localparam logic [13:0]       OUT_SCALE    = 14'd10000;
   localparam logic [12:0]       ROUND_HALF   = 13'd5000;
   localparam logic signed [31:0] SAT_LIMIT   = 32'sd2560000;

   // floor(n / 10000) == (n * RECIP) >> RECIP_SHIFT for 0 <= n < 2^22
   localparam int             RECIP_SHIFT = 36;
   localparam logic [22:0]    RECIP       = 23'd6871948;

   typedef struct packed {
      logic             capture;
      logic             zero_pixel;
      logic [COL_W-1:0] addr;
      logic             shift;
      logic             conv_en;
      logic             num_en;
      logic             div_en;
      logic             load;
      logic             border;
      logic             frame_end;
   } dp_cmd_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v < 11'd3) r = 11'd3;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

FILE: rtl/lsh_if.sv
// Valid/ready channel interfaces for the pixel input and the sharpened output.
interface lsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       flush;

   modport source (output valid, output pixel, output flush, input ready);
   modport sink   (input valid, input pixel, input flush, output ready);
endinterface

interface lsh_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sharpened;
   logic       frame_end;

   modport source (output valid, output sharpened, output frame_end, input ready);
   modport sink   (input valid, input sharpened, input frame_end, output ready);
endinterface

FILE: rtl/lsh_datapath.sv
// Datapath: line memories, 3x3 window, kernel arithmetic and output payload.
module lsh_datapath (
   input  logic                              clock,
   input  lsh_pkg::dp_cmd_type               cmd,
   input  logic [lsh_pkg::PIX_W-1:0]         pixel,
   input  logic                              filter_kind,
   input  logic [lsh_pkg::GAIN_W-1:0]        gain,
   output logic [lsh_pkg::PIX_W-1:0]         sharpened,
   output logic                              frame_end
);
   import lsh_pkg::*;

   logic [PIX_W-1:0] line_a [MAX_WIDTH];
   logic [PIX_W-1:0] line_b [MAX_WIDTH];

   logic [PIX_W-1:0] rd_a_ff, rd_b_ff, pix_ff;
   logic [COL_W-1:0] addr_ff;
   logic [PIX_W-1:0] win_ff [9];

   logic [SIZE_W-1:0]    nbr_sum;
   logic [SIZE_W-1:0]    coef;
   logic [18:0]          centre_prod;
   logic [17:0]          nbr_prod;
   logic signed [20:0]   conv_in, conv_ff;
   logic signed [9:0]    gain_s;
   logic signed [30:0]   gain_prod;
   logic [21:0]          base_term;
   logic signed [31:0]   num_in, num_ff;
   logic [44:0]          prod_in, prod_ff;
   logic                 neg_ff, over_ff;
   logic [PIX_W-1:0]     result;
   logic [PIX_W-1:0]     sharpened_ff;
   logic                 frame_end_ff;

   // line_a holds the row above (distance W), line_b two rows above (distance 2W)
   always_ff @(posedge clock) begin
      if (cmd.capture) rd_a_ff <= line_a[cmd.addr];
      if (cmd.shift) line_a[addr_ff] <= pix_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) rd_b_ff <= line_b[cmd.addr];
      if (cmd.shift) line_b[addr_ff] <= rd_a_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff <= cmd.addr;
         pix_ff  <= cmd.zero_pixel ? '0 : pixel;
      end
   end

   // window: index row*3+col, col 2 is the newest column
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= rd_b_ff;
         win_ff[5] <= rd_a_ff;
         win_ff[8] <= pix_ff;
      end
   end

   always_comb begin
      nbr_sum = 11'(win_ff[1]) + 11'(win_ff[3]) + 11'(win_ff[5]) + 11'(win_ff[7]);
      if (filter_kind != KIND_FIVE_POINT)
         nbr_sum = nbr_sum + 11'(win_ff[0]) + 11'(win_ff[2]) + 11'(win_ff[6])
                   + 11'(win_ff[8]);
   end

   assign coef        = 11'(gain) + ((filter_kind == KIND_FIVE_POINT) ? CENTRE_FIVE
                                                                       : CENTRE_NINE);
   assign centre_prod = 19'(coef) * 19'(win_ff[4]);
   assign nbr_prod    = 18'(nbr_sum) * 18'(NBR_SCALE);
   assign conv_in     = $signed({2'b00, centre_prod}) - $signed({3'b000, nbr_prod});

   assign gain_s    = $signed({1'b0, gain});
   assign gain_prod = 31'(gain_s) * 31'(conv_ff);
   assign base_term = 22'(win_ff[4]) * 22'(OUT_SCALE) + 22'(ROUND_HALF);
   assign num_in    = 32'(gain_prod) + $signed({10'd0, base_term});

   assign prod_in = 45'(num_ff[21:0]) * 45'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.conv_en) conv_ff <= conv_in;
      if (cmd.num_en) num_ff <= num_in;
      if (cmd.div_en) begin
         prod_ff <= prod_in;
         neg_ff  <= num_ff[31];
         over_ff <= !num_ff[31] && (num_ff >= SAT_LIMIT);
      end
   end

   always_comb begin
      if (cmd.border) result = win_ff[4];
      else if (neg_ff) result = '0;
      else if (over_ff) result = '1;
      else result = prod_ff[RECIP_SHIFT +: PIX_W];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sharpened_ff <= result;
         frame_end_ff <= cmd.frame_end;
      end
   end

   assign sharpened = sharpened_ff;
   assign frame_end = frame_end_ff;

endmodule

FILE: rtl/lsh_controller.sv
// Controller: raster counters, sequencing of each item and output valid.
module lsh_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_flush,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [lsh_pkg::SIZE_W-1:0]   width,
   input  logic [lsh_pkg::SIZE_W-1:0]   height,
   output lsh_pkg::dp_cmd_type          cmd
);
   import lsh_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_CONV  = 3'd2;
   localparam logic [2:0] ST_NUM   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_LOAD  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic             has_out_ff, has_out_in;
   logic             border_ff, border_in;
   logic             fend_ff, fend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic              accept, ignore, take, early, load;
   logic [SIZE_W-1:0] col_next, ocol_next;
   logic [ROW_W-1:0]  orow_next;
   logic              col_wrap, ocol_wrap;

   assign accept = req_valid && (state_ff == ST_IDLE);
   // a flush beat before any pixel of a frame does nothing
   assign ignore = req_flush && (in_col_ff == '0) && (in_row_ff == '0)
                   && (out_col_ff == '0) && (out_row_ff == '0);
   assign take   = accept && !ignore;
   assign early  = (in_row_ff == '0) || ((in_row_ff == 11'd1) && (in_col_ff == '0));

   assign col_next  = {1'b0, in_col_ff} + 11'd1;
   assign col_wrap  = col_next >= width;
   assign ocol_next = {1'b0, out_col_ff} + 11'd1;
   assign ocol_wrap = ocol_next >= width;
   assign orow_next = out_row_ff + 11'd1;

   assign border_in = (out_row_ff == '0) || (out_col_ff == '0)
                      || (orow_next >= height) || ocol_wrap;
   assign fend_in   = (out_row_ff >= height) || ((orow_next >= height) && ocol_wrap);
   assign has_out_in = !early;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (take) begin
         if (col_wrap) begin
            in_col_in = '0;
            if (in_row_ff != '1) in_row_in = in_row_ff + 11'd1;
         end else begin
            in_col_in = col_next[COL_W-1:0];
         end
         if (!early) begin
            if (fend_in) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_wrap) begin
               out_col_in = '0;
               out_row_in = orow_next;
            end else begin
               out_col_in = ocol_next[COL_W-1:0];
            end
         end
      end
   end

   assign load = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = take ? ST_SHIFT : ST_IDLE;
         ST_SHIFT: begin
            if (!has_out_ff) state_in = ST_IDLE;
            else if (border_ff) state_in = ST_LOAD;
            else state_in = ST_CONV;
         end
         ST_CONV:  state_in = ST_NUM;
         ST_NUM:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_LOAD;
         ST_LOAD:  state_in = load ? ST_IDLE : ST_LOAD;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         has_out_ff   <= 1'b0;
         border_ff    <= 1'b0;
         fend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            has_out_ff <= has_out_in;
            border_ff  <= border_in;
            fend_ff    <= fend_in;
         end
      end
   end

   always_comb begin
      cmd.capture    = take;
      cmd.zero_pixel = req_flush || (in_row_ff >= height);
      cmd.addr       = in_col_ff;
      cmd.shift      = (state_ff == ST_SHIFT);
      cmd.conv_en    = (state_ff == ST_CONV);
      cmd.num_en     = (state_ff == ST_NUM);
      cmd.div_en     = (state_ff == ST_DIV);
      cmd.load       = load;
      cmd.border     = border_ff;
      cmd.frame_end  = fend_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/laplacian_sharpen_3x3.sv
// Top level of the 3x3 Laplacian sharpening filter with its control registers.
//
// Pixels of an 8-bit gray frame enter in raster order on req_chan, one per
// beat; results leave on rsp_chan. The result for pixel k is produced by the
// beat that carries pixel k+W+1, so a frame is drained by W+1 trailing flush
// beats, and frame_end marks the W*H-th result. Border pixels pass unchanged.
// A beat is worked on alone: a beat that gives no result passes through the
// line memory read and the window shift, one that gives a border result adds
// the output load, and one that gives an interior result runs line memory read,
// window shift, three multiply stages and output load. A flush beat before the
// first pixel of a frame is accepted and gives no result.
// The output register lets the next beat be taken while a result waits; when
// the receiver stalls, a beat that needs the output register waits there.
// Reset (synchronous) clears counters and valid, and sets the registers to
// nine-point kernel, gain 1.00, 640x480. The line memories need no clearing.
// csr_* writes take effect at once and belong between frames.
module laplacian_sharpen_3x3 (
   input  logic                        clock,
   input  logic                        reset,
   lsh_req_if.sink                     req_chan,
   lsh_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_en,
   input  logic [1:0]                  csr_index,
   input  logic [lsh_pkg::CSR_W-1:0]   csr_wdata
);
   import lsh_pkg::*;

   logic              filter_kind_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SIZE_W-1:0] width_c, height_c;
   dp_cmd_type        cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_kind_ff <= 1'b1;
         gain_ff        <= 9'd100;
         width_ff       <= 11'd640;
         height_ff      <= 11'd480;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FILTER_KIND:  filter_kind_ff <= csr_wdata[0];
            CSR_GAIN:         gain_ff        <= csr_wdata[GAIN_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff       <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff      <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign width_c  = clamp_size(width_ff, SIZE_W'(MAX_WIDTH));
   assign height_c = clamp_size(height_ff, SIZE_W'(MAX_HEIGHT));

   lsh_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_flush (req_chan.flush),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .width     (width_c),
      .height    (height_c),
      .cmd       (cmd)
   );

   lsh_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .pixel       (req_chan.pixel),
      .filter_kind (filter_kind_ff),
      .gain        (gain_ff),
      .sharpened   (rsp_chan.sharpened),
      .frame_end   (rsp_chan.frame_end)
   );

endmodule

FILE: rtl/lsh_checker.sv
// Port-level checks for the sharpening filter, bound to the top level.
module lsh_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_flush,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] sharpened,
   input logic       frame_end
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sharpened) && $stable(frame_end))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a pixel beat always makes the block busy, so input ready drops after it
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_flush |=> !req_ready)
      else $error("input ready straight after a pixel beat");

   // a new result is loaded only from a working state, never while idle
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the input side was idle");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_flush (req_chan.flush),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .sharpened (rsp_chan.sharpened),
   .frame_end (rsp_chan.frame_end)
);
